@@ rtl/core/union_find_spanning_tree_joiner_core_defines.svh @@
// Assertion helpers for the union-find joiner checker.
// Each macro expects signals named clk and rst_n in the scope of use.
`ifndef UNION_FIND_SPANNING_TREE_JOINER_CORE_DEFINES_SVH
`define UNION_FIND_SPANNING_TREE_JOINER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UFSJ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define UFSJ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/ufsj_pkg.sv @@
// ----------------------------------------------------------------------------
// ufsj_pkg
// Types and constants shared by the union-find spanning tree joiner.
// ----------------------------------------------------------------------------
package ufsj_pkg;

    localparam int NODE_COUNT = 512;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int IDX_W      = 9;
    localparam int LEN_W      = 24;
    localparam int TOTAL_W    = 40;

    typedef logic [NODE_W-1:0]  node_t;
    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [LEN_W-1:0]   len_t;
    typedef logic [TOTAL_W-1:0] total_t;

    typedef struct packed {
        idx_t node_a;
        idx_t node_b;
        len_t edge_length;
        logic mandatory;
        logic last_edge;
    } edge_t;

    typedef struct packed {
        logic   merged;
        len_t   added_length;
        total_t total_length;
        logic   final_res;
    } result_t;

    // Parent table port requests from the sequencer
    typedef struct packed {
        logic  wr_en;
        node_t wr_addr;
        node_t wr_data;
        logic  rd_en;
        node_t rd_addr;
    } mem_req_t;

    // Finished edge handed to the accumulator and output stage
    typedef struct packed {
        logic valid;
        logic merged;
        len_t added;
        logic last;
    } step_t;

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_WALK_REQ = 3'd2;
    localparam logic [2:0] S_WALK     = 3'd3;
    localparam logic [2:0] S_CMP_REQ  = 3'd4;
    localparam logic [2:0] S_CMP      = 3'd5;
    localparam logic [2:0] S_LINK     = 3'd6;
    localparam logic [2:0] S_DONE     = 3'd7;

endpackage

@@ rtl/core/ufsj_if.sv @@
// ----------------------------------------------------------------------------
// ufsj_edge_if / ufsj_result_if
// Valid/ready channels carrying edge items and result items.
// ----------------------------------------------------------------------------
interface ufsj_edge_if
    import ufsj_pkg::*;
;
    logic  valid;
    logic  ready;
    edge_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ufsj_result_if
    import ufsj_pkg::*;
;
    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/ufsj_parent_mem.sv @@
// ----------------------------------------------------------------------------
// ufsj_parent_mem
// Parent table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ufsj_parent_mem
    import ufsj_pkg::*;
(
    input  logic     clk,
    input  mem_req_t req,
    output node_t    rd_data
);

    node_t mem [NODE_COUNT];
    node_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/ufsj_seq.sv @@
// ----------------------------------------------------------------------------
// ufsj_seq
// Sequencer: clears the parent table, walks each endpoint to its root one
// read per cycle, compresses the path, then links the two roots if they differ.
// ----------------------------------------------------------------------------
module ufsj_seq
    import ufsj_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    ufsj_edge_if.sink        edges,
    input  node_t            rd_data,
    input  logic             room,
    output mem_req_t         mem_req,
    output step_t            step
);

    logic [2:0] state_reg, state_next;
    node_t      clr_reg, clr_next;
    logic       side_reg, side_next;
    node_t      cur_reg, cur_next;
    node_t      start_reg, start_next;
    node_t      root_reg, root_next;
    node_t      ra_reg, ra_next;
    node_t      nodeb_reg, nodeb_next;
    len_t       len_reg, len_next;
    logic       must_reg, must_next;
    logic       last_reg, last_next;
    logic       merged_reg, merged_next;
    len_t       added_reg, added_next;
    logic       find_done;
    node_t      found_root;
    logic       in_range;

    assign in_range = (32'(edges.data.node_a) < 32'(NODE_COUNT))
                   && (32'(edges.data.node_b) < 32'(NODE_COUNT));

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        side_next   = side_reg;
        cur_next    = cur_reg;
        start_next  = start_reg;
        root_next   = root_reg;
        ra_next     = ra_reg;
        nodeb_next  = nodeb_reg;
        len_next    = len_reg;
        must_next   = must_reg;
        last_next   = last_reg;
        merged_next = merged_reg;
        added_next  = added_reg;
        find_done   = 1'b0;
        found_root  = cur_reg;
        mem_req     = '0;
        edges.ready = 1'b0;
        step        = '0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = clr_reg;
                mem_req.wr_data = clr_reg;
                clr_next        = clr_reg + node_t'(1);
                if (clr_reg == node_t'(NODE_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                edges.ready = 1'b1;
                if (edges.valid)
                begin
                    nodeb_next  = node_t'(edges.data.node_b);
                    len_next    = edges.data.edge_length;
                    must_next   = edges.data.mandatory;
                    last_next   = edges.data.last_edge;
                    cur_next    = node_t'(edges.data.node_a);
                    start_next  = node_t'(edges.data.node_a);
                    side_next   = 1'b0;
                    merged_next = 1'b0;
                    added_next  = '0;
                    // Drop an edge with an endpoint off the table
                    state_next  = in_range ? S_WALK_REQ : S_DONE;
                end
            end
            S_WALK_REQ:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = cur_reg;
                state_next      = S_WALK;
            end
            S_WALK:
            begin
                if (rd_data == cur_reg)
                begin
                    root_next = cur_reg;
                    if (start_reg == cur_reg)
                    begin
                        find_done  = 1'b1;
                        found_root = cur_reg;
                    end
                    else
                    begin
                        cur_next   = start_reg;
                        state_next = S_CMP_REQ;
                    end
                end
                else
                begin
                    // Hop up one level, reading the next parent at once
                    cur_next        = rd_data;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = rd_data;
                end
            end
            S_CMP_REQ:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = cur_reg;
                state_next      = S_CMP;
            end
            S_CMP:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = cur_reg;
                mem_req.wr_data = root_reg;
                if (rd_data == root_reg)
                begin
                    find_done  = 1'b1;
                    found_root = root_reg;
                end
                else
                begin
                    cur_next        = rd_data;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = rd_data;
                end
            end
            S_LINK:
            begin
                if (ra_reg != root_reg)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = ra_reg;
                    mem_req.wr_data = root_reg;
                    merged_next     = 1'b1;
                    added_next      = len_reg;
                end
                else
                begin
                    added_next = must_reg ? len_reg : '0;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (room)
                begin
                    step.valid  = 1'b1;
                    step.merged = merged_reg;
                    step.added  = added_reg;
                    step.last   = last_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Root of one endpoint known: start on the other or go link
        if (find_done)
        begin
            if (!side_reg)
            begin
                ra_next    = found_root;
                side_next  = 1'b1;
                cur_next   = nodeb_reg;
                start_next = nodeb_reg;
                state_next = S_WALK_REQ;
            end
            else
            begin
                root_next  = found_root;
                state_next = S_LINK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            side_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            side_reg  <= side_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        start_reg  <= start_next;
        root_reg   <= root_next;
        ra_reg     <= ra_next;
        nodeb_reg  <= nodeb_next;
        len_reg    <= len_next;
        must_reg   <= must_next;
        last_reg   <= last_next;
        merged_reg <= merged_next;
        added_reg  <= added_next;
    end

endmodule

@@ rtl/core/union_find_spanning_tree_joiner_core.sv @@
// ----------------------------------------------------------------------------
// union_find_spanning_tree_joiner_core
// Union-find edge joiner with path compression and a saturating total.
// ----------------------------------------------------------------------------
// Usage:
//   edges   : sink channel, one presorted edge per item (node_a, node_b,
//             edge_length, mandatory, last_edge).
//   results : source channel, one item per edge (merged, added_length,
//             total_length, final_res).
//   One edge at a time. Each endpoint is walked up to its root, and each
//   endpoint that is not already a root then gets a compression pass. The
//   parent table has one read port, so the chain is read one hop at a time.
//   After reset the parent table is cleared to identity, one entry per
//   cycle; edges.ready stays low until it is done, and the running total
//   starts at zero.
//   A result waits in the output register while results.ready is low; the
//   next edge is still taken and worked on, and its result holds in the
//   sequencer until the output register frees.
// ----------------------------------------------------------------------------
module union_find_spanning_tree_joiner_core
    import ufsj_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    ufsj_edge_if.sink     edges,
    ufsj_result_if.source results
);

    mem_req_t mem_req;
    node_t    rd_data;
    step_t    step;
    logic     room;

    total_t   total_reg, total_next;
    logic     out_valid_reg, out_valid_next;
    result_t  out_data_reg;
    logic [TOTAL_W:0] sum;

    assign room = !out_valid_reg || results.ready;

    ufsj_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .edges   (edges),
        .rd_data (rd_data),
        .room    (room),
        .mem_req (mem_req),
        .step    (step)
    );

    ufsj_parent_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // Saturate the running total at all ones
    assign sum = {1'b0, total_reg} + (TOTAL_W + 1)'(step.added);

    always_comb
    begin
        total_next     = total_reg;
        out_valid_next = out_valid_reg;
        if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (step.valid)
        begin
            total_next     = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step.valid)
        begin
            out_data_reg.merged       <= step.merged;
            out_data_reg.added_length <= step.added;
            out_data_reg.total_length <= total_next;
            out_data_reg.final_res    <= step.last;
        end
    end

    assign results.valid = out_valid_reg;
    assign results.data  = out_data_reg;

endmodule

@@ rtl/core/ufsj_checker.sv @@
// ----------------------------------------------------------------------------
// ufsj_checker
// Port-level checks on the joiner, bound to the top level.
// ----------------------------------------------------------------------------
`include "union_find_spanning_tree_joiner_core_defines.svh"

module ufsj_checker
    import ufsj_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   in_valid,
    input logic   in_ready,
    input logic   out_valid,
    input logic   out_ready,
    input total_t out_total
);

    `UFSJ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
    `UFSJ_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "edge taken while busy")
    `UFSJ_ASSERT_SAME(a_total_rises, out_valid && $past(out_valid) && rst_n && $past(rst_n), out_total >= $past(out_total), "running total went down")
    `UFSJ_ASSERT_SAME(a_clear_pass, $rose(rst_n), !in_ready, "edge taken during table clear")

endmodule

bind union_find_spanning_tree_joiner_core ufsj_checker u_ufsj_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (edges.valid),
    .in_ready  (edges.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_total (results.data.total_length)
);

@@ sim/ufsj_forest_checker.sv @@
// ----------------------------------------------------------------------------
// ufsj_forest_checker
// Watches the edge and result channels of the union-find joiner. Keeps its
// own disjoint-set forest and running total, predicts one result per
// accepted edge and compares every accepted result field by field.
// ----------------------------------------------------------------------------
module ufsj_forest_checker
    import ufsj_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    ufsj_edge_if   edges,
    ufsj_result_if results,
    output int     mismatches,
    output int     backlog,
    output int     links,
    output int     counted_only,
    output logic   saturated
);

    localparam total_t TOTAL_CAP = '1;

    node_t   parent_map [NODE_COUNT];
    total_t  sum_so_far;
    result_t pending_results [$];

    // Walk up to the root, then point every visited node straight at it.
    function automatic node_t root_of(input node_t n);
        node_t head;
        node_t up;
        int    hops;
        head = n;
        hops = 0;
        while (parent_map[head] != head && hops < NODE_COUNT)
        begin
            head = parent_map[head];
            hops++;
        end
        hops = 0;
        while (n != head && hops < NODE_COUNT)
        begin
            up = parent_map[n];
            parent_map[n] = head;
            n = up;
            hops++;
        end
        return head;
    endfunction

    function automatic result_t join_edge(input edge_t e);
        result_t          r;
        node_t            ra;
        node_t            rb;
        len_t             add;
        logic [TOTAL_W:0] wide;
        r.merged = 1'b0;
        add = '0;
        if (e.node_a < NODE_COUNT && e.node_b < NODE_COUNT)
        begin
            ra = root_of(node_t'(e.node_a));
            rb = root_of(node_t'(e.node_b));
            if (ra != rb)
            begin
                parent_map[ra] = rb;
                r.merged = 1'b1;
                add = e.edge_length;
            end
            else if (e.mandatory)
            begin
                add = e.edge_length;
            end
            wide = {1'b0, sum_so_far} + (TOTAL_W + 1)'(add);
            sum_so_far = wide[TOTAL_W] ? TOTAL_CAP : wide[TOTAL_W-1:0];
        end
        r.added_length = add;
        r.total_length = sum_so_far;
        r.final_res    = e.last_edge;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [TOTAL_W-1:0] want,
                               input logic [TOTAL_W-1:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    initial
    begin
        for (int i = 0; i < NODE_COUNT; i++)
        begin
            parent_map[i] = node_t'(i);
        end
        sum_so_far   = '0;
        mismatches   = 0;
        backlog      = 0;
        links        = 0;
        counted_only = 0;
        saturated    = 1'b0;
    end

    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n)
        begin
            // Push before pop: a result never belongs to the edge taken this cycle.
            if (edges.valid && edges.ready)
            begin
                want = join_edge(edges.data);
                pending_results = {pending_results, want};
                if (want.merged)
                    links++;
                else if (want.added_length != '0)
                    counted_only++;
                if (want.total_length == TOTAL_CAP)
                    saturated = 1'b1;
            end
            if (results.valid && results.ready)
            begin
                got = results.data;
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result: expected none, got 0x%0h", $time, got);
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("merged", TOTAL_W'(want.merged), TOTAL_W'(got.merged));
                    check_field("added_length", TOTAL_W'(want.added_length),
                                TOTAL_W'(got.added_length));
                    check_field("total_length", want.total_length, got.total_length);
                    check_field("final_res", TOTAL_W'(want.final_res), TOTAL_W'(got.final_res));
                end
            end
            backlog = pending_results.size();
        end
    end

endmodule

@@ sim/tb_union_find_spanning_tree_joiner_core.sv @@
// ----------------------------------------------------------------------------
// tb_union_find_spanning_tree_joiner_core
// Drives edges into the union-find joiner: directed corner cases, random
// chain builds, random and clustered pairs, repeats and noise, then a short
// burst of maximum-length mandatory self-loops and a tail of random edges.
// Both channels idle at random except in gap-free stretches; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_union_find_spanning_tree_joiner_core;
    import ufsj_pkg::*;

    localparam int RANDOM_ITEMS = 1600;
    localparam int BURST_ITEMS  = 30;
    localparam int IDLE_PCT     = 36;
    localparam int MAX_NODE     = 511;

    logic clk;
    logic rst_n;
    logic gaps_on;
    logic edge_taken;
    int   sent;
    int   mismatches;
    int   backlog;
    int   links;
    int   counted_only;
    logic saturated;

    ufsj_edge_if   edges_if ();
    ufsj_result_if results_if ();

    union_find_spanning_tree_joiner_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .edges   (edges_if),
        .results (results_if)
    );

    ufsj_forest_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .edges        (edges_if),
        .results      (results_if),
        .mismatches   (mismatches),
        .backlog      (backlog),
        .links        (links),
        .counted_only (counted_only),
        .saturated    (saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Latch the handshake at the edge so the driver can read it race-free.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            edge_taken <= 1'b0;
        else
            edge_taken <= edges_if.valid && edges_if.ready;
    end

    initial
    begin
        results_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            results_if.ready <= !gaps_on || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial
    begin
        #40_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic edge_t make_edge(input int a, input int b, input len_t len,
                                        input logic must, input logic last);
        edge_t e;
        e.node_a      = idx_t'(a);
        e.node_b      = idx_t'(b);
        e.edge_length = len;
        e.mandatory   = must;
        e.last_edge   = last;
        return e;
    endfunction

    function automatic len_t pick_length();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return len_t'($urandom);
        endcase
    endfunction

    function automatic logic pick_last();
        return $urandom_range(0, 15) == 0;
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic push_edge(input edge_t e);
        while (gaps_on && $urandom_range(0, 99) < IDLE_PCT)
        begin
            edges_if.valid <= 1'b0;
            @(negedge clk);
        end
        edges_if.valid <= 1'b1;
        edges_if.data  <= e;
        do @(negedge clk); while (!edge_taken);
        sent++;
    endtask

    initial
    begin
        int          span;
        int          base;
        int          reps;
        int          a;
        int          b;
        logic        flip;
        logic [63:0] raw;
        rst_n          = 1'b0;
        gaps_on        = 1'b1;
        sent           = 0;
        edges_if.valid = 1'b0;
        edges_if.data  = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Directed corners: extreme nodes and lengths, self edges, joined edges.
        push_edge(make_edge(0, MAX_NODE, len_t'(1), 1'b0, 1'b0));
        push_edge(make_edge(MAX_NODE, 0, '1, 1'b0, 1'b0));
        push_edge(make_edge(MAX_NODE, 0, '1, 1'b1, 1'b0));
        push_edge(make_edge(7, 7, len_t'(24'hABCDEF), 1'b0, 1'b0));
        push_edge(make_edge(7, 7, '1, 1'b1, 1'b0));
        push_edge(make_edge(9'h155, 9'h0AA, len_t'(24'h555555), 1'b1, 1'b1));
        push_edge(make_edge(9'h0AA, 9'h155, len_t'(24'hAAAAAA), 1'b0, 1'b0));
        push_edge(make_edge(1, 2, '0, 1'b0, 1'b0));
        push_edge(make_edge(2, 1, '0, 1'b1, 1'b0));
        // Build a chain 10 -> 15, then force a deep find with compression.
        for (int k = 10; k < 15; k++)
        begin
            push_edge(make_edge(k, k + 1, len_t'(k * 256), 1'b0, 1'b0));
        end
        push_edge(make_edge(10, 20, len_t'(24'h000100), 1'b0, 1'b0));
        push_edge(make_edge(12, 20, len_t'(24'h123456), 1'b1, 1'b0));
        push_edge(make_edge(20, 10, len_t'(24'h654321), 1'b0, 1'b1));
        push_edge(make_edge(MAX_NODE, MAX_NODE, '1, 1'b1, 1'b1));

        while (sent < RANDOM_ITEMS)
        begin
            gaps_on = !(sent >= 700 && sent < 1000);
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    // Chain build, forward or as a star, then a query across it.
                    span = $urandom_range(3, 40);
                    base = $urandom_range(0, MAX_NODE - span);
                    flip = 1'($urandom_range(0, 1));
                    for (int k = 0; k < span; k++)
                    begin
                        if (flip)
                            push_edge(make_edge(base + k + 1, base + k, pick_length(),
                                                $urandom_range(0, 3) == 0, pick_last()));
                        else
                            push_edge(make_edge(base + k, base + k + 1, pick_length(),
                                                $urandom_range(0, 3) == 0, pick_last()));
                    end
                    push_edge(make_edge(base, base + span, pick_length(),
                                        1'($urandom_range(0, 1)), pick_last()));
                end
                4, 5, 6:
                begin
                    reps = $urandom_range(1, 10);
                    repeat (reps)
                        push_edge(make_edge($urandom_range(0, MAX_NODE),
                                            $urandom_range(0, MAX_NODE), pick_length(),
                                            1'($urandom_range(0, 1)), pick_last()));
                end
                7:
                begin
                    base = $urandom_range(0, MAX_NODE - 15);
                    reps = $urandom_range(2, 12);
                    repeat (reps)
                        push_edge(make_edge(base + $urandom_range(0, 15),
                                            base + $urandom_range(0, 15), pick_length(),
                                            1'($urandom_range(0, 1)), pick_last()));
                end
                8:
                begin
                    // Same pair again and again; half the time a self edge.
                    a = $urandom_range(0, MAX_NODE);
                    b = $urandom_range(0, 1) ? a : $urandom_range(0, MAX_NODE);
                    reps = $urandom_range(2, 5);
                    repeat (reps)
                        push_edge(make_edge(a, b, pick_length(), 1'($urandom_range(0, 1)),
                                            pick_last()));
                end
                default:
                begin
                    raw = {$urandom, $urandom};
                    push_edge(raw[$bits(edge_t)-1:0]);
                end
            endcase
        end

        // Back-to-back maximum-length mandatory self edges.
        gaps_on = 1'b0;
        for (int i = 0; i < BURST_ITEMS; i++)
        begin
            a = $urandom_range(0, MAX_NODE);
            push_edge(make_edge(a, a, '1, 1'b1, i == BURST_ITEMS - 1));
        end
        gaps_on = 1'b1;
        repeat (12)
            push_edge(make_edge($urandom_range(0, MAX_NODE), $urandom_range(0, MAX_NODE),
                                pick_length(), 1'($urandom_range(0, 1)), pick_last()));
        edges_if.valid <= 1'b0;

        while (backlog != 0) @(negedge clk);
        repeat (40) @(negedge clk);

        $display("Ran %0d edges: %0d links made, %0d lengths counted on joined endpoints.",
                 sent, links, counted_only);
        $display("Total %s saturation; random idles and stalls on both channels.",
                 saturated ? "reached" : "never reached");
        if (mismatches == 0 && backlog == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
